>>> sv/rocpf_pkg.sv
package rocpf_pkg;

    localparam int CHANNELS_DEF          = 16;
    localparam int FILTERED_CHANNELS_DEF = 16;

    localparam int FUNC_W   = 2;
    localparam int CHAN_W   = 4;
    localparam int SAMPLE_W = 24;
    localparam int TICK_W   = 32;
    localparam int RATE_W   = 48;
    localparam int SCALE_W  = 8;
    localparam int COEF_W   = 16;
    localparam int FRAC_W   = 16;
    localparam int DIVD_W   = SAMPLE_W + FRAC_W;   // |d| << 16
    localparam int ACC_W    = RATE_W + 2;          // rate - smoothed, plus headroom
    localparam int CNT_W    = $clog2(DIVD_W + 1);
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_NORMAL = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEED   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_SCALE_CHAN0  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_CHAN1  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_CHAN2  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_OTHERS = 2'd3;

    localparam logic [SCALE_W-1:0] SCALE_CHAN0_RST  = 8'd100;
    localparam logic [SCALE_W-1:0] SCALE_CHAN1_RST  = 8'd10;
    localparam logic [SCALE_W-1:0] SCALE_CHAN2_RST  = 8'd100;
    localparam logic [SCALE_W-1:0] SCALE_OTHERS_RST = 8'd0;

    localparam logic [COEF_W-1:0] K_SLOW = 16'd2064;    // 0.0315
    localparam logic [COEF_W-1:0] K_FAST = 16'd43647;   // 0.666

    localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

    typedef enum logic {
        ALU_DIV,
        ALU_MUL
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    typedef struct packed {
        logic rd_en;
        logic wr_hist;
        logic wr_smooth;
    } store_ctl_t;

endpackage

>>> sv/rocpf_alu.sv
module rocpf_alu (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rocpf_pkg::alu_ctl_t          ctl,
    input  logic [rocpf_pkg::ACC_W-1:0]  opnd_a,
    input  logic [rocpf_pkg::DIVD_W-1:0] opnd_l,
    output logic [rocpf_pkg::ACC_W-1:0]  hi,
    output logic [rocpf_pkg::DIVD_W-1:0] lo,
    output logic                         done
);
    import rocpf_pkg::*;

    // DIV: hi = remainder, lo = dividend shifting into quotient, a = divisor
    // MUL: hi = accumulator, lo[COEF_W-1:0] = coefficient bits, a = multiplicand
    logic [ACC_W-1:0]  hi_reg, hi_next;
    logic [DIVD_W-1:0] lo_reg, lo_next;
    logic [ACC_W-1:0]  a_reg;
    alu_op_t           op_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [TICK_W:0]   shifted;
    logic [ACC_W-1:0]  add_x, add_y, sum;

    always_comb begin
        shifted = {hi_reg[TICK_W-1:0], lo_reg[DIVD_W-1]};
        if (op_reg == ALU_DIV) begin
            add_x = ACC_W'(shifted);
            add_y = ~a_reg;
        end else begin
            add_x = hi_reg;
            add_y = lo_reg[0] ? a_reg : '0;
        end
        sum = add_x + add_y + ACC_W'(op_reg == ALU_DIV);
        if (op_reg == ALU_DIV) begin
            hi_next = sum[ACC_W-1] ? ACC_W'(shifted) : sum;
            lo_next = {lo_reg[DIVD_W-2:0], ~sum[ACC_W-1]};
        end else begin
            hi_next = {sum[ACC_W-1], sum[ACC_W-1:1]};
            lo_next = {lo_reg[DIVD_W-1:COEF_W], sum[0], lo_reg[COEF_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= (ctl.op == ALU_DIV) ? CNT_W'(DIVD_W) : CNT_W'(COEF_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            hi_reg <= '0;
            lo_reg <= opnd_l;
            a_reg  <= opnd_a;
            op_reg <= ctl.op;
        end else if (busy_reg) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign hi   = hi_reg;
    assign lo   = lo_reg;
    assign done = done_reg;

endmodule

>>> sv/rocpf_store.sv
module rocpf_store #(
    parameter  int CHANNELS = rocpf_pkg::CHANNELS_DEF,
    localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rocpf_pkg::store_ctl_t                 ctl,
    input  logic [AW-1:0]                         addr,
    input  logic signed [rocpf_pkg::SAMPLE_W-1:0] wr_sample,
    input  logic [rocpf_pkg::TICK_W-1:0]          wr_tick,
    input  logic signed [rocpf_pkg::RATE_W-1:0]   wr_smooth,
    output logic signed [rocpf_pkg::SAMPLE_W-1:0] rd_sample,
    output logic [rocpf_pkg::TICK_W-1:0]          rd_tick,
    output logic signed [rocpf_pkg::RATE_W-1:0]   rd_smooth
);
    import rocpf_pkg::*;

    logic signed [SAMPLE_W-1:0] sample_mem [CHANNELS];
    logic [TICK_W-1:0]          tick_mem   [CHANNELS];
    logic signed [RATE_W-1:0]   smooth_mem [CHANNELS];

    logic [CHANNELS-1:0] hist_vld_reg;
    logic [CHANNELS-1:0] smooth_vld_reg;

    logic signed [SAMPLE_W-1:0] sample_rd_reg;
    logic [TICK_W-1:0]          tick_rd_reg;
    logic signed [RATE_W-1:0]   smooth_rd_reg;
    logic                       hist_hit_reg;
    logic                       smooth_hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_vld_reg   <= '0;
            smooth_vld_reg <= '0;
        end else begin
            if (ctl.wr_hist) begin
                hist_vld_reg[addr] <= 1'b1;
            end
            if (ctl.wr_smooth) begin
                smooth_vld_reg[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_hist) begin
            sample_mem[addr] <= wr_sample;
            tick_mem[addr]   <= wr_tick;
        end
        if (ctl.wr_smooth) begin
            smooth_mem[addr] <= wr_smooth;
        end
        if (ctl.rd_en) begin
            sample_rd_reg  <= sample_mem[addr];
            tick_rd_reg    <= tick_mem[addr];
            smooth_rd_reg  <= smooth_mem[addr];
            hist_hit_reg   <= hist_vld_reg[addr];
            smooth_hit_reg <= smooth_vld_reg[addr];
        end
    end

    assign rd_sample = hist_hit_reg   ? sample_rd_reg : '0;
    assign rd_tick   = hist_hit_reg   ? tick_rd_reg   : '0;
    assign rd_smooth = smooth_hit_reg ? smooth_rd_reg : '0;

endmodule

>>> sv/rate_of_change_peak_filter.sv
// Per-channel rate-of-change estimator with a peak-hold smoother. Each item
// gives (sample - previous sample) * 2^16 / (tick - previous tick) for its
// channel in signed Q32.16, scales positive rates by the channel's scale
// register and, on filtered channels, smooths all but seed and clear items
// with 0.666 when the new rate's magnitude is not below the stored one and
// 0.0315 otherwise. One item at a time passes through a single shared adder:
// a 40-step restoring divide and a 16-step coefficient multiply. The divide
// is skipped for a zero tick difference, the multiply on unfiltered channels
// and both for a channel outside the store; a new item is taken only once
// the last result is registered. Per-channel state sits in small memories
// that reset to zero through valid bits; no clearing pass is needed.
module rate_of_change_peak_filter #(
    parameter int CHANNELS          = rocpf_pkg::CHANNELS_DEF,
    parameter int FILTERED_CHANNELS = rocpf_pkg::FILTERED_CHANNELS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [rocpf_pkg::FUNC_W-1:0]          s_func,
    input  logic [rocpf_pkg::CHAN_W-1:0]          s_channel,
    input  logic signed [rocpf_pkg::SAMPLE_W-1:0] s_sample,
    input  logic [rocpf_pkg::TICK_W-1:0]          s_tick,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rocpf_pkg::RATE_W-1:0]   m_filtered_rate,
    output logic                                  m_divide_fault,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rocpf_pkg::PADDR_W-1:0]         paddr,
    input  logic [rocpf_pkg::PDATA_W-1:0]         pwdata,
    output logic [rocpf_pkg::PDATA_W-1:0]         prdata,
    output logic                                  pready
);
    import rocpf_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_SCALE,
        ST_FILT,
        ST_MUL,
        ST_OUT
    } state_t;

    // configuration
    logic [SCALE_W-1:0] scale_chan0_reg, scale_chan1_reg, scale_chan2_reg, scale_others_reg;
    logic [REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_chan0_reg  <= SCALE_CHAN0_RST;
            scale_chan1_reg  <= SCALE_CHAN1_RST;
            scale_chan2_reg  <= SCALE_CHAN2_RST;
            scale_others_reg <= SCALE_OTHERS_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_SCALE_CHAN0:  scale_chan0_reg  <= pwdata[SCALE_W-1:0];
                REG_SCALE_CHAN1:  scale_chan1_reg  <= pwdata[SCALE_W-1:0];
                REG_SCALE_CHAN2:  scale_chan2_reg  <= pwdata[SCALE_W-1:0];
                REG_SCALE_OTHERS: scale_others_reg <= pwdata[SCALE_W-1:0];
                default:          scale_others_reg <= scale_others_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SCALE_CHAN0:  prdata = PDATA_W'(scale_chan0_reg);
            REG_SCALE_CHAN1:  prdata = PDATA_W'(scale_chan1_reg);
            REG_SCALE_CHAN2:  prdata = PDATA_W'(scale_chan2_reg);
            REG_SCALE_OTHERS: prdata = PDATA_W'(scale_others_reg);
            default:          prdata = '0;
        endcase
    end

    // sequencer registers
    state_t                     state_reg, state_next;
    logic [FUNC_W-1:0]          func_reg, func_next;
    logic [CHAN_W-1:0]          ch_reg, ch_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [TICK_W-1:0]          tick_reg, tick_next;
    logic signed [RATE_W-1:0]   rate_reg, rate_next;
    logic                       fault_reg, fault_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [RATE_W-1:0]   m_rate_reg, m_rate_next;
    logic                       m_fault_reg, m_fault_next;

    // store and shared unit
    store_ctl_t                 st_ctl;
    logic [AW-1:0]              st_addr;
    logic [AW+CHAN_W-1:0]       s_ch_ext, ch_ext;
    logic signed [RATE_W-1:0]   st_wr_smooth;
    logic signed [SAMPLE_W-1:0] prev_sample;
    logic [TICK_W-1:0]          prev_tick;
    logic signed [RATE_W-1:0]   smooth;

    alu_ctl_t                   alu_ctl;
    logic [ACC_W-1:0]           alu_a;
    logic [DIVD_W-1:0]          alu_l;
    logic [ACC_W-1:0]           alu_hi;
    logic [DIVD_W-1:0]          alu_lo;
    logic                       alu_done;

    // datapath
    logic signed [SAMPLE_W:0]   d;
    logic                       d_neg;
    logic [SAMPLE_W:0]          d_mag;
    logic [TICK_W-1:0]          t;
    logic signed [RATE_W-1:0]   sat_rate;
    logic signed [RATE_W-1:0]   q_rate;
    logic [SCALE_W-1:0]         sc;
    logic [RATE_W+SCALE_W-2:0]  prod;
    logic signed [RATE_W-1:0]   scaled;
    logic [RATE_W-1:0]          abs_r, abs_s;
    logic [COEF_W-1:0]          coef;
    logic signed [RATE_W-1:0]   mul_result;
    logic                       ch_in_range, ch_filtered;

    assign s_ch_ext = (AW+CHAN_W)'(s_channel);
    assign ch_ext   = (AW+CHAN_W)'(ch_reg);
    assign st_addr  = (state_reg == ST_IDLE) ? s_ch_ext[AW-1:0] : ch_ext[AW-1:0];

    assign ch_in_range = (32'(ch_reg) < 32'(CHANNELS));
    assign ch_filtered = (32'(ch_reg) < 32'(FILTERED_CHANNELS));

    always_comb begin
        d      = {sample_reg[SAMPLE_W-1], sample_reg} - {prev_sample[SAMPLE_W-1], prev_sample};
        d_neg  = d[SAMPLE_W];
        d_mag  = d_neg ? -d : d;
        t      = tick_reg - prev_tick;
        if (d == '0) begin
            sat_rate = '0;
        end else begin
            sat_rate = d_neg ? RATE_MIN : RATE_MAX;
        end
        q_rate = d_neg ? -RATE_W'(alu_lo) : RATE_W'(alu_lo);

        unique case (ch_reg)
            4'd0:    sc = scale_chan0_reg;
            4'd1:    sc = scale_chan1_reg;
            4'd2:    sc = scale_chan2_reg;
            default: sc = scale_others_reg;
        endcase
        prod   = rate_reg[RATE_W-2:0] * sc;
        scaled = (prod[RATE_W+SCALE_W-2:RATE_W-1] != '0) ? RATE_MAX
                                                        : {1'b0, prod[RATE_W-2:0]};

        abs_r = rate_reg[RATE_W-1] ? -rate_reg : rate_reg;
        abs_s = smooth[RATE_W-1]   ? -smooth   : smooth;
        coef  = (abs_r < abs_s) ? K_SLOW : K_FAST;

        mul_result = smooth + alu_hi[RATE_W-1:0];
    end

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        ch_next      = ch_reg;
        sample_next  = sample_reg;
        tick_next    = tick_reg;
        rate_next    = rate_reg;
        fault_next   = fault_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rate_next  = m_rate_reg;
        m_fault_next = m_fault_reg;

        st_ctl       = '0;
        st_wr_smooth = (func_reg == FUNC_CLEAR) ? '0 : rate_reg;
        alu_ctl      = '{start: 1'b0, op: ALU_DIV};
        alu_a        = ACC_W'(t);
        alu_l        = {d_mag[SAMPLE_W-1:0], {FRAC_W{1'b0}}};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    st_ctl.rd_en = 1'b1;
                    func_next    = s_func;
                    ch_next      = s_channel;
                    sample_next  = s_sample;
                    tick_next    = s_tick;
                    state_next   = ST_LOAD;
                end
            end
            ST_LOAD: begin
                fault_next = 1'b0;
                if (!ch_in_range) begin
                    rate_next  = '0;
                    state_next = ST_OUT;
                end else if (t == '0) begin
                    fault_next = 1'b1;
                    rate_next  = sat_rate;
                    state_next = ST_SCALE;
                end else begin
                    alu_ctl.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (alu_done) begin
                    rate_next  = q_rate;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (!rate_reg[RATE_W-1] && rate_reg != '0) begin
                    rate_next = scaled;
                end
                state_next = ST_FILT;
            end
            ST_FILT: begin
                st_ctl.wr_hist = 1'b1;
                state_next     = ST_OUT;
                if (ch_filtered) begin
                    priority if (func_reg == FUNC_SEED) begin
                        st_ctl.wr_smooth = 1'b1;
                    end else if (func_reg == FUNC_CLEAR) begin
                        st_ctl.wr_smooth = 1'b1;
                        rate_next        = '0;
                    end else begin
                        alu_ctl = '{start: 1'b1, op: ALU_MUL};
                        alu_a   = ACC_W'(rate_reg) - ACC_W'(smooth);
                        alu_l   = DIVD_W'(coef);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                st_wr_smooth = mul_result;
                if (alu_done) begin
                    st_ctl.wr_smooth = 1'b1;
                    rate_next        = mul_result;
                    state_next       = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rate_next  = rate_reg;
                    m_fault_next = fault_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg    <= func_next;
        ch_reg      <= ch_next;
        sample_reg  <= sample_next;
        tick_reg    <= tick_next;
        rate_reg    <= rate_next;
        fault_reg   <= fault_next;
        m_rate_reg  <= m_rate_next;
        m_fault_reg <= m_fault_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_filtered_rate = m_rate_reg;
    assign m_divide_fault  = m_fault_reg;

    rocpf_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (st_ctl),
        .addr      (st_addr),
        .wr_sample (sample_reg),
        .wr_tick   (tick_reg),
        .wr_smooth (st_wr_smooth),
        .rd_sample (prev_sample),
        .rd_tick   (prev_tick),
        .rd_smooth (smooth)
    );

    rocpf_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (alu_ctl),
        .opnd_a  (alu_a),
        .opnd_l  (alu_l),
        .hi      (alu_hi),
        .lo      (alu_lo),
        .done    (alu_done)
    );

endmodule

>>> dv/rocpf_checker.sv
module rocpf_checker
    import rocpf_pkg::*;
#(
    parameter int CHANNELS          = CHANNELS_DEF,
    parameter int FILTERED_CHANNELS = FILTERED_CHANNELS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [FUNC_W-1:0]          s_func,
    input  logic [CHAN_W-1:0]          s_channel,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic [TICK_W-1:0]          s_tick,

    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [RATE_W-1:0]   m_filtered_rate,
    input  logic                       m_divide_fault,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    input  logic [PDATA_W-1:0]         prdata,
    input  logic                       pready,

    output int                         errors,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint RMAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint RMIN = -RMAX - 1;

    typedef struct {
        logic [CHAN_W-1:0]        channel;
        logic signed [RATE_W-1:0] rate;
        logic                     fault;
    } rate_result_t;

    rate_result_t pending_rates[$];

    logic [SCALE_W-1:0] scale_c0, scale_c1, scale_c2, scale_rest;
    int                 last_sample[CHANNELS];
    logic [TICK_W-1:0]  last_tick[CHANNELS];
    longint             smoothed[CHANNELS];

    initial begin
        errors      = 0;
        outstanding = 0;
    end

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [SCALE_W-1:0] scale_of(logic [CHAN_W-1:0] ch);
        case (ch)
            0:       return scale_c0;
            1:       return scale_c1;
            2:       return scale_c2;
            default: return scale_rest;
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_SCALE_CHAN0: return scale_c0;
            REG_SCALE_CHAN1: return scale_c1;
            REG_SCALE_CHAN2: return scale_c2;
            default:         return scale_rest;
        endcase
    endfunction

    // Works out the result of one item and advances the channel history.
    function automatic rate_result_t predict_rate(logic [FUNC_W-1:0] fn,
                                                  logic [CHAN_W-1:0] ch,
                                                  logic signed [SAMPLE_W-1:0] smp,
                                                  logic [TICK_W-1:0] tk);
        longint             diff, rate, quo, scl, s, res;
        logic [TICK_W-1:0]  dt;
        logic [COEF_W-1:0]  k;
        logic signed [127:0] prod;
        rate_result_t       r;
        r.channel = ch;
        r.fault   = 1'b0;
        r.rate    = '0;
        if (ch >= CHANNELS) return r;

        diff = longint'(smp) - longint'(last_sample[ch]);
        dt   = tk - last_tick[ch];
        if (dt == 0) begin
            r.fault = 1'b1;
            if (diff > 0)      rate = RMAX;
            else if (diff < 0) rate = RMIN;
            else               rate = 0;
        end else begin
            quo  = (magnitude(diff) <<< FRAC_W) / longint'(dt);
            rate = (diff < 0) ? -quo : quo;
        end
        if (rate > 0) begin
            scl = longint'(scale_of(ch));
            if (scl == 0)               rate = 0;
            else if (rate > RMAX / scl) rate = RMAX;
            else                        rate = rate * scl;
        end

        last_sample[ch] = smp;
        last_tick[ch]   = tk;

        if (ch >= FILTERED_CHANNELS) begin
            res = rate;
        end else begin
            case (fn)
                FUNC_SEED: begin
                    smoothed[ch] = rate;
                    res = rate;
                end
                FUNC_CLEAR: begin
                    smoothed[ch] = 0;
                    res = 0;
                end
                default: begin
                    s    = smoothed[ch];
                    k    = (magnitude(rate) < magnitude(s)) ? K_SLOW : K_FAST;
                    prod = 128'(rate - s);
                    prod = prod * $signed({112'd0, k});
                    res  = s + longint'(prod >>> COEF_W);
                    smoothed[ch] = res;
                end
            endcase
        end
        r.rate = res[RATE_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        rate_result_t exp_r;
        logic [SCALE_W-1:0] want;
        if (!aresetn) begin
            scale_c0   <= SCALE_CHAN0_RST;
            scale_c1   <= SCALE_CHAN1_RST;
            scale_c2   <= SCALE_CHAN2_RST;
            scale_rest <= SCALE_OTHERS_RST;
            for (int i = 0; i < CHANNELS; i++) begin
                last_sample[i] = 0;
                last_tick[i]   = '0;
                smoothed[i]    = 0;
            end
            pending_rates.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_rates.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected item rate=%0d fault=%0b", $realtime,
                                 m_filtered_rate, m_divide_fault);
                    errors++;
                end else begin
                    exp_r = pending_rates.pop_front();
                    if (m_filtered_rate !== exp_r.rate || m_divide_fault !== exp_r.fault) begin
                        if (errors < 10)
                            $display("%0t: ch %0d rate exp %0d got %0d, fault exp %0b got %0b",
                                     $realtime, exp_r.channel, exp_r.rate, m_filtered_rate,
                                     exp_r.fault, m_divide_fault);
                        errors++;
                    end
                end
            end

            if (s_valid && s_ready)
                pending_rates.push_back(predict_rate(s_func, s_channel, s_sample, s_tick));

            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_SCALE_CHAN0: scale_c0   <= pwdata[SCALE_W-1:0];
                        REG_SCALE_CHAN1: scale_c1   <= pwdata[SCALE_W-1:0];
                        REG_SCALE_CHAN2: scale_c2   <= pwdata[SCALE_W-1:0];
                        default:         scale_rest <= pwdata[SCALE_W-1:0];
                    endcase
                end else begin
                    want = reg_value(paddr[3:2]);
                    if (prdata !== {{(PDATA_W-SCALE_W){1'b0}}, want}) begin
                        if (errors < 10)
                            $display("%0t: reg read at 0x%0h exp 0x%0h got 0x%0h", $realtime,
                                     paddr, want, prdata);
                        errors++;
                    end
                end
            end
        end
        outstanding <= pending_rates.size();
    end

endmodule

>>> dv/tb.sv
module tb;
    import rocpf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 260;
    localparam int PHASES          = 6;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;   // unused code, behaves as normal

    logic                       aclk    = 1'b0;
    logic                       aresetn = 1'b0;

    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic [FUNC_W-1:0]          s_func    = FUNC_NORMAL;
    logic [CHAN_W-1:0]          s_channel = '0;
    logic signed [SAMPLE_W-1:0] s_sample  = '0;
    logic [TICK_W-1:0]          s_tick    = '0;

    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [RATE_W-1:0]   m_filtered_rate;
    logic                       m_divide_fault;

    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [PADDR_W-1:0]         paddr   = '0;
    logic [PDATA_W-1:0]         pwdata  = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    int mismatch_count;
    int rates_in_flight;
    int cycle_count = 0;

    int run_left[2] = '{0, 0};
    bit tight[2];

    logic signed [SAMPLE_W-1:0] stim_sample[16];
    logic [TICK_W-1:0]          stim_tick[16];

    rate_of_change_peak_filter dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_func, .s_channel, .s_sample, .s_tick,
        .m_valid, .m_ready, .m_filtered_rate, .m_divide_fault,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    rocpf_checker chk (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_func, .s_channel, .s_sample, .s_tick,
        .m_valid, .m_ready, .m_filtered_rate, .m_divide_fault,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .errors(mismatch_count), .outstanding(rates_in_flight)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // side 0 is the sender, side 1 the receiver; runs of no waiting now and then
    function automatic int pick_gap(int side);
        if (run_left[side] == 0) begin
            run_left[side] = $urandom_range(8, 40);
            tight[side]    = ($urandom_range(0, 3) == 0);
        end
        run_left[side] -= 1;
        return tight[side] ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic send_item(logic [FUNC_W-1:0] fn, logic [CHAN_W-1:0] ch,
                             logic signed [SAMPLE_W-1:0] smp, logic [TICK_W-1:0] tk);
        int gap;
        gap = pick_gap(0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= fn;
        s_channel <= ch;
        s_sample  <= smp;
        s_tick    <= tk;
        do @(posedge aclk); while (!(s_valid && s_ready));
        stim_sample[ch] = smp;
        stim_tick[ch]   = tk;
    endtask

    task automatic apb_access(logic wr, logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_scales();
        apb_access(1'b0, REG_SCALE_CHAN0, '0);
        apb_access(1'b0, REG_SCALE_CHAN1, '0);
        apb_access(1'b0, REG_SCALE_CHAN2, '0);
        apb_access(1'b0, REG_SCALE_OTHERS, '0);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (rates_in_flight != 0);
    endtask

    task automatic random_item();
        logic [FUNC_W-1:0]          fn;
        logic [CHAN_W-1:0]          ch;
        logic signed [SAMPLE_W-1:0] smp;
        logic [TICK_W-1:0]          tk;
        int                         pick, step;
        pick = $urandom_range(0, 99);
        if (pick < 78)      fn = FUNC_NORMAL;
        else if (pick < 86) fn = FUNC_SEED;
        else if (pick < 92) fn = FUNC_CLEAR;
        else                fn = FUNC_SPARE;

        ch = ($urandom_range(0, 99) < 60) ? CHAN_W'($urandom_range(0, 3))
                                          : CHAN_W'($urandom_range(0, 15));

        if ($urandom_range(0, 99) < 30) begin
            smp = SAMPLE_W'($urandom);
        end else begin
            step = $urandom_range(0, 1 << $urandom_range(0, 20));
            if ($urandom_range(0, 1)) step = -step;
            smp = SAMPLE_W'(stim_sample[ch] + step);
        end

        pick = $urandom_range(0, 99);
        if (pick < 8)       tk = stim_tick[ch];
        else if (pick < 20) tk = $urandom;
        else                tk = stim_tick[ch] + $urandom_range(1, 1 << $urandom_range(0, 16));

        send_item(fn, ch, smp, tk);
    endtask

    // result side
    initial begin
        int gap;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = pick_gap(1);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin
        logic [SCALE_W-1:0] setting[4];
        for (int c = 0; c < 16; c++) begin
            stim_sample[c] = '0;
            stim_tick[c]   = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_scales();

        // directed items at reset scales
        send_item(FUNC_NORMAL, 4'd0, 24'sd1000, 32'd16);
        send_item(FUNC_NORMAL, 4'd0, 24'sd2000, 32'd16);        // zero tick, rising
        send_item(FUNC_NORMAL, 4'd0, 24'sd1500, 32'd16);        // zero tick, falling
        send_item(FUNC_NORMAL, 4'd0, 24'sd1500, 32'd16);        // zero tick, flat
        send_item(FUNC_NORMAL, 4'd0, 24'sd1600, 32'd17);
        send_item(FUNC_SEED,   4'd1, 24'sh7FFFFF, 32'd1);
        send_item(FUNC_CLEAR,  4'd1, -24'sd100, 32'd2);
        send_item(FUNC_SPARE,  4'd1, 24'sd500, 32'd5);
        send_item(FUNC_NORMAL, 4'd2, 24'sh800000, 32'hFFFF_FFFF);
        send_item(FUNC_NORMAL, 4'd2, 24'sh7FFFFF, 32'h0000_0000); // tick wraps
        send_item(FUNC_NORMAL, 4'd2, 24'sh800000, 32'h0000_0001);
        send_item(FUNC_NORMAL, 4'd3, 24'sd5000, 32'd100);        // zero scale
        send_item(FUNC_NORMAL, 4'd15, -24'sd5000, 32'd200);
        send_item(FUNC_SEED,   4'd7, -24'sd1000000, 32'd1);
        send_item(FUNC_NORMAL, 4'd7, -24'sd1000010, 32'd1001);  // smaller: slow smoothing
        send_item(FUNC_NORMAL, 4'd7, -24'sd2000010, 32'd1002);  // larger: fast smoothing
        send_item(FUNC_NORMAL, 4'd9, 24'sh7FFFFF, 32'hFFFF_FFFF);
        send_item(FUNC_NORMAL, 4'd9, 24'sh800000, 32'hFFFF_FFFF);
        send_item(FUNC_CLEAR,  4'd9, 24'sd0, 32'd0);
        send_item(FUNC_SEED,   4'd15, 24'sd0, 32'h8000_0000);
        send_item(FUNC_SPARE,  4'd14, 24'sh7FFFFF, 32'h8000_0001);

        for (int p = 1; p <= PHASES; p++) begin
            drain();
            repeat (8) @(posedge aclk);
            for (int r = 0; r < 4; r++) begin
                case (p)
                    1:       setting[r] = 8'd255;
                    2:       setting[r] = 8'd0;
                    3:       setting[r] = 8'd1;
                    default: setting[r] = SCALE_W'($urandom_range(0, 255));
                endcase
            end
            apb_access(1'b1, REG_SCALE_CHAN0,
                       {(PDATA_W-SCALE_W)'($urandom_range(0, 2**24 - 1)), setting[0]});
            apb_access(1'b1, REG_SCALE_CHAN1,
                       {(PDATA_W-SCALE_W)'($urandom_range(0, 2**24 - 1)), setting[1]});
            apb_access(1'b1, REG_SCALE_CHAN2,
                       {(PDATA_W-SCALE_W)'($urandom_range(0, 2**24 - 1)), setting[2]});
            apb_access(1'b1, REG_SCALE_OTHERS,
                       {(PDATA_W-SCALE_W)'($urandom_range(0, 2**24 - 1)), setting[3]});
            read_scales();
            repeat (ITEMS_PER_PHASE) random_item();
        end

        drain();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
sv/rocpf_pkg.sv
sv/rocpf_alu.sv
sv/rocpf_store.sv
sv/rate_of_change_peak_filter.sv
dv/rocpf_checker.sv
dv/tb.sv
